### hdl/assert_macros.svh
// Assertion macros shared by the point transform unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is high.
`define PAF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define PAF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hdl/paf_pkg.sv
// Types, codes and constant tables of the point transform unit.
// Depends on nothing; imported by the top unit and by paf_sincos.
package paf_pkg;

   localparam logic [2:0] ACT_SCALE        = 3'd0;
   localparam logic [2:0] ACT_ROTATE       = 3'd1;
   localparam logic [2:0] ACT_MOVE_POINT   = 3'd2;
   localparam logic [2:0] ACT_MOVE_CENTRE  = 3'd3;
   localparam logic [2:0] ACT_SET_CENTRE   = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam int FULL_TURN_DEG    = 360;
   localparam int HALF_TURN_DEG    = 180;
   localparam int QUARTER_TURN_DEG = 90;
   localparam int ANGLE_FRAC       = 24;
   localparam int TRIG_FRAC        = 30;

   localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_DEG_Q24 [32] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
      32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
      32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
      32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
      32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_SIMPLE, ST_SCALE_ISSUE, ST_SCALE_W1, ST_SCALE_W2,
      ST_ROT_START, ST_ROT_ANGLE, ST_MUL_ISSUE, ST_MUL_W1, ST_MUL_W2,
      ST_ROT_SUM, ST_OUT
   } paf_state_type;

   typedef enum logic [2:0] {
      SC_IDLE, SC_MOD, SC_WRAP, SC_FOLD, SC_ITER, SC_DONE
   } paf_sc_phase_type;

   typedef struct packed {
      logic signed [33:0] sin_v;
      logic signed [33:0] cos_v;
      logic               done;
   } paf_trig_type;

endpackage

### hdl/point_affine_transform_3d_unit.sv
// Point transform unit: scale, rotate or translate one 3D point about a stored centre.
// Depends on paf_pkg, paf_mul, paf_sincos and assert_macros.svh.
//
// One transfer is taken at a time; the unit is busy until the result is in its output
// register. A rotate works through each axis in turn: the per-axis angle reduction, the
// CORDIC iterations and four passes through the single shared multiplier, whose
// registered result is waited for on each product. The centre resets to zero.
`include "assert_macros.svh"

module point_affine_transform_3d_unit import paf_pkg::*; #(
   parameter int COORD_WIDTH  = 32,
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_x, in_y, in_z, param_a, param_b, param_c from the lowest bit up.
   input  logic [191:0] req_tdata,
   // action.
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_z from the lowest bit up.
   output logic [95:0]  rsp_tdata,
   // status.
   output logic [1:0]   rsp_tuser
);

   localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam logic signed [39:0] CMAX = (40'sd1 <<< (CW - 1)) - 40'sd1;
   localparam logic signed [39:0] CMIN = -CMAX - 40'sd1;

   function automatic logic signed [31:0] sext_cw(input logic [31:0] v);
      logic [31:0] t;
      t = v << (32 - CW);
      return $signed(t) >>> (32 - CW);
   endfunction

   function automatic logic signed [31:0] sat_val(input logic signed [39:0] v);
      if (v > CMAX) return 32'(CMAX);
      if (v < CMIN) return 32'(CMIN);
      return 32'(v);
   endfunction

   function automatic logic sat_hit(input logic signed [39:0] v);
      return (v > CMAX) || (v < CMIN);
   endfunction

   paf_state_type      state_ff, state_in;
   logic [2:0]         act_ff, act_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [31:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic               flag_ff, flag_in;
   logic [1:0]         status_ff, status_in;
   logic [1:0]         ax_ff, ax_in, stage_ff, stage_in, mi_ff, mi_in;
   logic signed [39:0] accu_ff, accu_in, accv_ff, accv_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic signed [31:0] sp, sc, sk, ru, rv, rcu, rcv, rang;
   logic signed [33:0] op_a, op_b;
   logic               use_frac;
   logic signed [39:0] mul_res;
   logic               sc_start;
   paf_trig_type       trig;
   logic signed [39:0] s0, s1, s2;
   logic signed [31:0] r0, r1;
   logic               out_load;

   paf_mul #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock    (clock),
      .op_a     (op_a),
      .op_b     (op_b),
      .use_frac (use_frac),
      .result   (mul_res)
   );

   paf_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sincos (
      .clock (clock),
      .reset (reset),
      .start (sc_start),
      .angle (rang),
      .trig  (trig)
   );

   always_comb begin
      case (ax_ff)
         2'd0:    begin sp = px_ff; sc = cx_ff; sk = pa_ff; end
         2'd1:    begin sp = py_ff; sc = cy_ff; sk = pb_ff; end
         default: begin sp = pz_ff; sc = cz_ff; sk = pc_ff; end
      endcase
      case (stage_ff)
         2'd0: begin
            ru = py_ff; rv = pz_ff; rcu = cy_ff; rcv = cz_ff; rang = pa_ff;
         end
         2'd1: begin
            ru = px_ff; rv = pz_ff; rcu = cx_ff; rcv = cz_ff; rang = pb_ff;
         end
         default: begin
            ru = px_ff; rv = py_ff; rcu = cx_ff; rcv = cy_ff; rang = pc_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (act_ff)
               ACT_SCALE: begin
                  if (pa_ff == 0 || pb_ff == 0 || pc_ff == 0) state_in = ST_OUT;
                  else state_in = ST_SCALE_ISSUE;
               end
               ACT_ROTATE: state_in = ST_ROT_START;
               default:    state_in = ST_SIMPLE;
            endcase
         end
         ST_SIMPLE:      state_in = ST_OUT;
         ST_SCALE_ISSUE: state_in = ST_SCALE_W1;
         ST_SCALE_W1:    state_in = ST_SCALE_W2;
         ST_SCALE_W2:    state_in = (ax_ff == 2'd2) ? ST_OUT : ST_SCALE_ISSUE;
         ST_ROT_START:   state_in = ST_ROT_ANGLE;
         ST_ROT_ANGLE:   if (trig.done) state_in = ST_MUL_ISSUE;
         ST_MUL_ISSUE:   state_in = ST_MUL_W1;
         ST_MUL_W1:      state_in = ST_MUL_W2;
         ST_MUL_W2:      state_in = (mi_ff == 2'd3) ? ST_ROT_SUM : ST_MUL_ISSUE;
         ST_ROT_SUM:     state_in = (stage_ff == 2'd2) ? ST_OUT : ST_ROT_START;
         ST_OUT:         if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      act_in = act_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      pa_in = pa_ff; pb_in = pb_ff; pc_in = pc_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      flag_in = flag_ff;
      status_in = status_ff;
      ax_in = ax_ff; stage_in = stage_ff; mi_in = mi_ff;
      accu_in = accu_ff; accv_in = accv_ff;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      out_load = 1'b0;
      sc_start = (state_ff == ST_ROT_START);
      s0 = '0; s1 = '0; s2 = '0;
      r0 = '0; r1 = '0;
      if (state_ff == ST_SCALE_ISSUE) begin
         op_a = 34'(sp) - 34'(sc);
         op_b = 34'(sk);
         use_frac = 1'b1;
      end else begin
         op_a = (mi_ff == 2'd0 || mi_ff == 2'd2) ? 34'(ru) - 34'(rcu) : 34'(rv) - 34'(rcv);
         op_b = (mi_ff == 2'd0 || mi_ff == 2'd3) ? trig.cos_v : trig.sin_v;
         use_frac = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            act_in = req_tuser;
            px_in = sext_cw(req_tdata[31:0]);
            py_in = sext_cw(req_tdata[63:32]);
            pz_in = sext_cw(req_tdata[95:64]);
            pa_in = req_tdata[127:96];
            pb_in = req_tdata[159:128];
            pc_in = req_tdata[191:160];
            flag_in = 1'b0;
            status_in = STATUS_OK;
            ax_in = 2'd0;
            stage_in = 2'd0;
         end
         ST_DECODE: begin
            if (act_ff == ACT_SCALE && (pa_ff == 0 || pb_ff == 0 || pc_ff == 0)) begin
               status_in = STATUS_ZERO;
            end
         end
         ST_SIMPLE: begin
            case (act_ff)
               ACT_MOVE_POINT: begin
                  s0 = 40'(px_ff) + 40'(pa_ff);
                  s1 = 40'(py_ff) + 40'(pb_ff);
                  s2 = 40'(pz_ff) + 40'(pc_ff);
                  px_in = sat_val(s0); py_in = sat_val(s1); pz_in = sat_val(s2);
                  flag_in = sat_hit(s0) || sat_hit(s1) || sat_hit(s2);
               end
               ACT_MOVE_CENTRE: begin
                  s0 = 40'(cx_ff) + 40'(pa_ff);
                  s1 = 40'(cy_ff) + 40'(pb_ff);
                  s2 = 40'(cz_ff) + 40'(pc_ff);
                  px_in = sat_val(s0); py_in = sat_val(s1); pz_in = sat_val(s2);
                  cx_in = sat_val(s0); cy_in = sat_val(s1); cz_in = sat_val(s2);
                  flag_in = sat_hit(s0) || sat_hit(s1) || sat_hit(s2);
               end
               ACT_SET_CENTRE: begin
                  cx_in = px_ff; cy_in = py_ff; cz_in = pz_ff;
               end
               default: begin
               end
            endcase
         end
         ST_SCALE_W2: begin
            s0 = 40'(sc) + mul_res;
            r0 = sat_val(s0);
            if (sat_hit(s0)) flag_in = 1'b1;
            case (ax_ff)
               2'd0:    px_in = r0;
               2'd1:    py_in = r0;
               default: pz_in = r0;
            endcase
            ax_in = ax_ff + 2'd1;
         end
         ST_ROT_START: mi_in = 2'd0;
         ST_MUL_W2: begin
            case (mi_ff)
               2'd0:    accu_in = mul_res;
               2'd1:    accu_in = accu_ff + mul_res;
               2'd2:    accv_in = -mul_res;
               default: accv_in = accv_ff + mul_res;
            endcase
            mi_in = mi_ff + 2'd1;
         end
         ST_ROT_SUM: begin
            s0 = accu_ff + 40'(rcu);
            s1 = accv_ff + 40'(rcv);
            r0 = sat_val(s0);
            r1 = sat_val(s1);
            if (sat_hit(s0) || sat_hit(s1)) flag_in = 1'b1;
            case (stage_ff)
               2'd0:    begin py_in = r0; pz_in = r1; end
               2'd1:    begin px_in = r0; pz_in = r1; end
               default: begin px_in = r0; py_in = r1; end
            endcase
            stage_in = stage_ff + 2'd1;
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               rsp_data_in = {pz_ff, py_ff, px_ff};
               rsp_status_in = flag_ff ? STATUS_SAT : status_ff;
            end
         end
         default: begin
         end
      endcase
      rsp_tvalid_in = (rsp_tvalid_ff && !rsp_tready) || out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
      act_ff <= act_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      pa_ff <= pa_in; pb_ff <= pb_in; pc_ff <= pc_in;
      flag_ff <= flag_in;
      status_ff <= status_in;
      ax_ff <= ax_in; stage_ff <= stage_in; mi_ff <= mi_in;
      accu_ff <= accu_in; accv_ff <= accv_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `PAF_ASSERT_NXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "accept not busy")
   `PAF_ASSERT_IMP(a_status, clock, reset, rsp_tvalid, rsp_tuser != 2'b11, "bad status code")
   `PAF_ASSERT_IMP(a_trig_wait, clock, reset, trig.done, state_ff == ST_ROT_ANGLE, "stray trig")

endmodule

### hdl/paf_mul.sv
// Shared multiplier with round-to-nearest (ties away from zero) and clamp.
// Depends on nothing outside; the product and then the rounded result are registered.
module paf_mul #(
   parameter int CW        = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic signed [33:0] op_a,
   input  logic signed [33:0] op_b,
   input  logic               use_frac,
   output logic signed [39:0] result
);

   localparam logic [68:0] LIM      = 69'd1 << (CW + 1);
   localparam logic [68:0] RND_FRAC = 69'd1 << (FRAC_BITS - 1);
   localparam logic [68:0] RND_TRIG = 69'd1 << 29;

   logic signed [67:0] prod_ff;
   logic               frac_ff;
   logic signed [39:0] result_ff;
   logic [68:0]        mag;
   logic [68:0]        rq;
   logic [68:0]        rq_lim;
   logic signed [39:0] result_in;

   always_comb begin
      mag = prod_ff[67] ? 69'(-prod_ff) : 69'(prod_ff);
      if (frac_ff) begin
         rq = (mag + RND_FRAC) >> FRAC_BITS;
      end else begin
         rq = (mag + RND_TRIG) >> 30;
      end
      rq_lim = (rq > LIM) ? LIM : rq;
      result_in = prod_ff[67] ? -(40'(rq_lim)) : 40'(rq_lim);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= op_a * op_b;
      frac_ff   <= use_frac;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

### hdl/paf_sincos.sv
// Angle reduction and CORDIC sine and cosine, one step per cycle.
// Depends on paf_pkg for the arctangent table, gain and phase codes.
module paf_sincos import paf_pkg::*; #(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] angle,
   output paf_trig_type       trig
);

   localparam longint FULL       = 64'(FULL_TURN_DEG) << FRAC_BITS;
   localparam longint HALF       = 64'(HALF_TURN_DEG) << FRAC_BITS;
   localparam longint QUARTER    = 64'(QUARTER_TURN_DEG) << FRAC_BITS;
   localparam longint OFFSET_MOD = (64'd1 << 31) % FULL;
   localparam int     KTOP_RAW   = 32 - $clog2(FULL);
   localparam int     KTOP       = (KTOP_RAW < 0) ? 0 : KTOP_RAW;
   localparam int     CNT_W      = $clog2(CORDIC_STEPS + 1);
   localparam int     Z_SHIFT    = ANGLE_FRAC - FRAC_BITS;

   paf_sc_phase_type   phase_ff, phase_in;
   logic [31:0]        rem_ff, rem_in;
   logic [4:0]         step_ff, step_in;
   logic signed [34:0] a_ff, a_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [39:0] z_ff, z_in;
   logic               flip_ff, flip_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [63:0]        sub;
   logic signed [34:0] t;
   logic [4:0]         k;

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         SC_IDLE:  if (start) phase_in = SC_MOD;
         SC_MOD:   if (step_ff == 5'd0) phase_in = SC_WRAP;
         SC_WRAP:  phase_in = SC_FOLD;
         SC_FOLD:  phase_in = SC_ITER;
         SC_ITER:  if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) phase_in = SC_DONE;
         SC_DONE:  phase_in = SC_IDLE;
         default:  phase_in = SC_IDLE;
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      step_in = step_ff;
      a_in    = a_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      sub     = 64'(FULL) << step_ff;
      t       = a_ff;
      k       = 5'(cnt_ff);
      case (phase_ff)
         SC_IDLE: begin
            rem_in  = {~angle[31], angle[30:0]};
            step_in = 5'(KTOP);
         end
         SC_MOD: begin
            if ({32'd0, rem_ff} >= sub) rem_in = rem_ff - sub[31:0];
            step_in = step_ff - 5'd1;
         end
         SC_WRAP: begin
            t = $signed({3'b000, rem_ff}) - 35'(OFFSET_MOD);
            if (t < 0) t = t + 35'(FULL);
            a_in = t;
         end
         SC_FOLD: begin
            t = a_ff;
            flip_in = 1'b0;
            if (t > 35'(HALF)) t = t - 35'(FULL);
            if (t > 35'(QUARTER)) begin
               t = 35'(HALF) - t;
               flip_in = 1'b1;
            end else if (t < -35'(QUARTER)) begin
               t = -35'(HALF) - t;
               flip_in = 1'b1;
            end
            z_in   = 40'(t) <<< Z_SHIFT;
            x_in   = CORDIC_INV_GAIN;
            y_in   = '0;
            cnt_in = '0;
         end
         SC_ITER: begin
            if (z_ff >= 0) begin
               x_in = x_ff - (y_ff >>> k);
               y_in = y_ff + (x_ff >>> k);
               z_in = z_ff - 40'(ATAN_DEG_Q24[k]);
            end else begin
               x_in = x_ff + (y_ff >>> k);
               y_in = y_ff - (x_ff >>> k);
               z_in = z_ff + 40'(ATAN_DEG_Q24[k]);
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      rem_ff  <= rem_in;
      step_ff <= step_in;
      a_ff    <= a_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
   end

   assign trig.sin_v = y_ff;
   assign trig.cos_v = flip_ff ? -x_ff : x_ff;
   assign trig.done  = (phase_ff == SC_DONE);

endmodule
